[rtl/core/cva_pkg.sv]
// ----------------------------------------------------------------------------
// cva_pkg
// shared constants, types and table helpers for the cordic atan2 pipeline
// ----------------------------------------------------------------------------
package cva_pkg;

	// default build configuration
	localparam int ITERATIONS_DEF      = 12;
	localparam int COORD_WIDTH_DEF     = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 13;

	// fixed field widths
	localparam int OUT_WIDTH = 16;
	localparam int CFG_WIDTH = 15;
	localparam logic [CFG_WIDTH-1:0] ZERO_LIMIT_RESET = 15'd1;

	// arctangent table held in q28
	localparam int TABLE_FRAC = 28;
	localparam int TABLE_LEN  = 16;

	localparam logic [63:0] PI_Q28 = 64'd843314857;

	localparam logic [63:0] ATAN_Q28 [TABLE_LEN] = '{
		64'd210828714, 64'd124459457, 64'd65760959, 64'd33381290,
		64'd16755422,  64'd8385879,   64'd4193963,  64'd2097109,
		64'd1048571,   64'd524287,    64'd262144,   64'd131072,
		64'd65536,     64'd32768,     64'd16384,    64'd8192
	};

	// control bits that travel with each pipeline stage
	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

	// round a q28 constant half up to the angle format
	function automatic logic [63:0] round_q28(input logic [63:0] q, input int frac);
		int          s;
		logic [63:0] half;
		s    = TABLE_FRAC - frac;
		half = (s > 0) ? (64'd1 << (s - 1)) : 64'd0;
		return (q + half) >> s;
	endfunction

	// table entry for one micro-rotation
	function automatic logic [63:0] atan_entry(input int step, input int frac);
		return round_q28(ATAN_Q28[step], frac);
	endfunction

endpackage

[rtl/core/cva_pre.sv]
// ----------------------------------------------------------------------------
// cva_pre
// first stage: near-zero test, left half-plane fold and angle preset
// ----------------------------------------------------------------------------
module cva_pre #(
	parameter int COORD_WIDTH     = cva_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = cva_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int XW              = COORD_WIDTH + 2,
	parameter int ANG_W           = ANGLE_FRAC_BITS + 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [COORD_WIDTH-1:0]     x_value,
	input  logic signed [COORD_WIDTH-1:0]     y_value,
	input  logic [cva_pkg::CFG_WIDTH-1:0]     zero_limit,
	output cva_pkg::ctl_t                     ctl_s1,
	output logic signed [XW-1:0]              x_s1,
	output logic signed [XW-1:0]              y_s1,
	output logic signed [ANG_W-1:0]           ang_s1
);
	import cva_pkg::*;

	localparam int MAG_W = COORD_WIDTH + 1;
	localparam int CMP_W = (MAG_W > CFG_WIDTH) ? MAG_W : CFG_WIDTH;
	localparam logic signed [ANG_W-1:0] PI_ANG = ANG_W'(round_q28(PI_Q28, ANGLE_FRAC_BITS));

	logic signed [XW-1:0]    x_ext;
	logic signed [XW-1:0]    y_ext;
	logic [MAG_W-1:0]        x_mag;
	logic [MAG_W-1:0]        y_mag;
	logic [CMP_W-1:0]        lim_ext;
	logic                    is_zero;
	logic                    x_neg;
	logic signed [XW-1:0]    x_fold;
	logic signed [XW-1:0]    y_fold;
	logic signed [ANG_W-1:0] ang_init;

	// magnitudes and near-zero compare
	always_comb begin
		x_ext   = XW'(x_value);
		y_ext   = XW'(y_value);
		x_mag   = x_ext[XW-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
		y_mag   = y_ext[XW-1] ? MAG_W'(-y_ext) : MAG_W'(y_ext);
		lim_ext = CMP_W'(zero_limit);
		is_zero = (CMP_W'(x_mag) < lim_ext) && (CMP_W'(y_mag) < lim_ext);
	end

	// fold negative x into the right half plane with a pi preset
	always_comb begin
		x_neg = x_ext[XW-1];
		if (x_neg) begin
			x_fold   = -x_ext;
			y_fold   = -y_ext;
			ang_init = y_ext[XW-1] ? -PI_ANG : PI_ANG;
		end else begin
			x_fold   = x_ext;
			y_fold   = y_ext;
			ang_init = '0;
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.zero  <= is_zero;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_fold;
			y_s1   <= y_fold;
			ang_s1 <= ang_init;
		end
	end

endmodule

[rtl/core/cva_iter.sv]
// ----------------------------------------------------------------------------
// cva_iter
// one vectoring micro-rotation with its pipeline register
// ----------------------------------------------------------------------------
module cva_iter #(
	parameter int STEP            = 0,
	parameter int ANGLE_FRAC_BITS = cva_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int XW              = cva_pkg::COORD_WIDTH_DEF + 2,
	parameter int ANG_W           = ANGLE_FRAC_BITS + 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  cva_pkg::ctl_t           ctl_in,
	input  logic signed [XW-1:0]    x_in,
	input  logic signed [XW-1:0]    y_in,
	input  logic signed [ANG_W-1:0] ang_in,
	output cva_pkg::ctl_t           ctl_s1,
	output logic signed [XW-1:0]    x_s1,
	output logic signed [XW-1:0]    y_s1,
	output logic signed [ANG_W-1:0] ang_s1
);
	import cva_pkg::*;

	localparam logic signed [ANG_W-1:0] T_ANG = ANG_W'(atan_entry(STEP, ANGLE_FRAC_BITS));

	logic signed [XW-1:0]    x_sh;
	logic signed [XW-1:0]    y_sh;
	logic signed [XW-1:0]    x_nxt;
	logic signed [XW-1:0]    y_nxt;
	logic signed [ANG_W-1:0] ang_nxt;

	// rotate toward the x axis, direction from the sign of y
	always_comb begin
		x_sh = x_in >>> STEP;
		y_sh = y_in >>> STEP;
		if (!y_in[XW-1]) begin
			x_nxt   = x_in + y_sh;
			y_nxt   = y_in - x_sh;
			ang_nxt = ang_in + T_ANG;
		end else begin
			x_nxt   = x_in - y_sh;
			y_nxt   = y_in + x_sh;
			ang_nxt = ang_in - T_ANG;
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_nxt;
			y_s1   <= y_nxt;
			ang_s1 <= ang_nxt;
		end
	end

endmodule

[rtl/core/cva_sat.sv]
// ----------------------------------------------------------------------------
// cva_sat
// last stage: zero override, saturation and the output register
// ----------------------------------------------------------------------------
module cva_sat #(
	parameter int ANGLE_FRAC_BITS = cva_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int ANG_W           = ANGLE_FRAC_BITS + 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  cva_pkg::ctl_t                          ctl_in,
	input  logic signed [ANG_W-1:0]                ang_in,
	output logic                                   out_valid_s1,
	output logic signed [cva_pkg::OUT_WIDTH-1:0]   angle_s1
);
	import cva_pkg::*;

	localparam int SW = (ANG_W > OUT_WIDTH) ? ANG_W : OUT_WIDTH;
	localparam logic signed [SW-1:0] OMAX = SW'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] OMIN = SW'(-(64'sd1 <<< (OUT_WIDTH - 1)));

	logic signed [SW-1:0]        ang_ext;
	logic signed [OUT_WIDTH-1:0] angle_nxt;

	// clamp to the output range, force zero for the near-origin case
	always_comb begin
		ang_ext = SW'(ang_in);
		if (ctl_in.zero) begin
			angle_nxt = '0;
		end else if (ang_ext > OMAX) begin
			angle_nxt = OMAX[OUT_WIDTH-1:0];
		end else if (ang_ext < OMIN) begin
			angle_nxt = OMIN[OUT_WIDTH-1:0];
		end else begin
			angle_nxt = ang_ext[OUT_WIDTH-1:0];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (en) begin
			out_valid_s1 <= ctl_in.valid;
		end
	end

	// output data
	always_ff @(posedge clk) begin
		if (en) begin
			angle_s1 <= angle_nxt;
		end
	end

endmodule

[rtl/core/cordic_vectoring_atan2.sv]
// ----------------------------------------------------------------------------
// cordic_vectoring_atan2
// pipelined cordic vectoring unit returning atan2(y, x) in q3.13 radians
// ----------------------------------------------------------------------------
// usage:
//   s_* : request stream, one (x, y) pair per accepted beat
//   m_* : result stream, one angle per request, in request order
//   cfg_*: write of the zero limit register, taken in any cycle
// pipeline: one fold stage, one stage per micro-rotation and one output
//   stage, each a register between input accept and m_tvalid.
// throughput: one request per cycle when not stalled; every stage is a
//   register slice fed by a single adder per coordinate, so nothing iterates.
// stall: all stages share one advance enable, high while the output
//   register is empty or being taken; when m_tready is low with a result
//   waiting, the whole pipe holds and s_tready drops, nothing is lost.
// reset: arst_n clears all stage valid bits and sets the zero limit to 1;
//   the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module cordic_vectoring_atan2 #(
	parameter  int ITERATIONS      = cva_pkg::ITERATIONS_DEF,
	parameter  int COORD_WIDTH     = cva_pkg::COORD_WIDTH_DEF,
	parameter  int ANGLE_FRAC_BITS = cva_pkg::ANGLE_FRAC_BITS_DEF,
	localparam int S_DATA_W        = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [S_DATA_W-1:0]                s_tdata,  // x_value, y_value, zero pad
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cva_pkg::OUT_WIDTH-1:0]      m_tdata,  // angle
	// zero limit write
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cva_pkg::CFG_WIDTH-1:0]      cfg_data
);
	import cva_pkg::*;

	localparam int XW    = COORD_WIDTH + 2;
	localparam int ANG_W = ANGLE_FRAC_BITS + 4;

	logic [CFG_WIDTH-1:0]     zero_limit_q;
	logic                     en;
	ctl_t                     ctl_p   [ITERATIONS+1];
	logic signed [XW-1:0]     x_p     [ITERATIONS+1];
	logic signed [XW-1:0]     y_p     [ITERATIONS+1];
	logic signed [ANG_W-1:0]  ang_p   [ITERATIONS+1];
	logic signed [OUT_WIDTH-1:0] angle_out;

	// zero limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_limit_q <= ZERO_LIMIT_RESET;
		end else if (cfg_valid) begin
			zero_limit_q <= cfg_data;
		end
	end

	// shared advance enable
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// fold stage
	cva_pre #(
		.COORD_WIDTH     (COORD_WIDTH),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.XW              (XW),
		.ANG_W           (ANG_W)
	) u_pre (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.x_value    (s_tdata[COORD_WIDTH-1:0]),
		.y_value    (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.zero_limit (zero_limit_q),
		.ctl_s1     (ctl_p[0]),
		.x_s1       (x_p[0]),
		.y_s1       (y_p[0]),
		.ang_s1     (ang_p[0])
	);

	// micro-rotation stages
	for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
		cva_iter #(
			.STEP            (k),
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
			.XW              (XW),
			.ANG_W           (ANG_W)
		) u_iter (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_p[k]),
			.x_in   (x_p[k]),
			.y_in   (y_p[k]),
			.ang_in (ang_p[k]),
			.ctl_s1 (ctl_p[k+1]),
			.x_s1   (x_p[k+1]),
			.y_s1   (y_p[k+1]),
			.ang_s1 (ang_p[k+1])
		);
	end

	// output stage
	cva_sat #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.ANG_W           (ANG_W)
	) u_sat (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.ctl_in       (ctl_p[ITERATIONS]),
		.ang_in       (ang_p[ITERATIONS]),
		.out_valid_s1 (m_tvalid),
		.angle_s1     (angle_out)
	);

	assign m_tdata = angle_out;

endmodule

[rtl/core/cva_checker.sv]
// ----------------------------------------------------------------------------
// cva_checker
// port-level checks on the atan2 pipeline, bound to the top level
// ----------------------------------------------------------------------------
module cva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// a stalled output stalls the request side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while output stalled");

	// an empty output register never blocks requests
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("requests blocked with empty output");

	// a valid result carries fully defined angle bits
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown(m_tdata))
		else $error("undefined angle on a valid result");

endmodule

bind cordic_vectoring_atan2 cva_checker u_cva_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
